/* design/cep_pkg.sv */
`timescale 1ns / 1ps
package cep_pkg;

  localparam int MAX_CONSTRAINT = 7;
  localparam int MAX_PATTERN    = 16;
  localparam int MAX_REPEAT     = 4;

  // Field widths of the register map
  localparam int K_W     = 3;
  localparam int GEN_W   = 7;
  localparam int REP_W   = 3;
  localparam int PLEN_W  = 5;
  localparam int PMASK_W = 16;

  localparam int REG_W  = MAX_CONSTRAINT;
  localparam int HIST_W = MAX_CONSTRAINT - 1;
  localparam int HIDX_W = (HIST_W > 1) ? $clog2(HIST_W) : 1;
  localparam int CNT_W  = $clog2(HIST_W + 1);
  localparam int KE_W   = $clog2(MAX_CONSTRAINT + 1);
  localparam int POS_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CAND_W = $clog2(2 * MAX_REPEAT);

  localparam int QDEPTH = 2;
  localparam int QIDX_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int REGIDX_W = 3;
  localparam int ADDR_W   = REGIDX_W + 2;

  localparam logic [REGIDX_W-1:0] REG_CONSTRAINT_LEN = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_GEN_UPPER      = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_GEN_LOWER      = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_TAIL_BITING    = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_REPEAT_COUNT   = 3'd4;
  localparam logic [REGIDX_W-1:0] REG_PUNCT_LEN      = 3'd5;
  localparam logic [REGIDX_W-1:0] REG_PUNCT_MASK     = 3'd6;

  typedef struct packed {
    logic [K_W-1:0]     constraint_len;
    logic [GEN_W-1:0]   gen_upper;
    logic [GEN_W-1:0]   gen_lower;
    logic               tail_biting;
    logic [REP_W-1:0]   repeat_count;
    logic [PLEN_W-1:0]  punct_len;
    logic [PMASK_W-1:0] punct_mask;
  } cfg_t;

  // One clocked register value for the back end to code
  typedef struct packed {
    logic [REG_W-1:0] sreg;
    logic             emit;
    logic             last;   // closes the request's run
    logic             fin;
  } cmd_t;

  function automatic logic [KE_W-1:0] eff_k(input logic [K_W-1:0] k);
    int kv;
    kv = int'(k);
    if (kv < 2) kv = 2;
    if (kv > MAX_CONSTRAINT) kv = MAX_CONSTRAINT;
    return KE_W'(kv);
  endfunction

endpackage

/* design/cep_ifs.sv */
`timescale 1ns / 1ps
interface cep_in_if;
  logic valid;
  logic ready;
  logic msg_bit;
  logic final_bit;

  modport source (output valid, output msg_bit, output final_bit, input ready);
  modport sink (input valid, input msg_bit, input final_bit, output ready);
endinterface

interface cep_out_if;
  logic valid;
  logic ready;
  logic code_bit;
  logic run_end;
  logic message_end;

  modport source (output valid, output code_bit, output run_end, output message_end,
                  input ready);
  modport sink (input valid, input code_bit, input run_end, input message_end,
                output ready);
  modport monitor (input valid, input ready, input code_bit, input run_end,
                   input message_end);
endinterface

/* design/cep_regs.sv */
`timescale 1ns / 1ps
module cep_regs import cep_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output cfg_t              cfg
);

  cfg_t cfg_r, cfg_nxt;
  logic [REGIDX_W-1:0] idx;
  logic wr_en;

  assign idx   = paddr[ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_CONSTRAINT_LEN: cfg_nxt.constraint_len = pwdata[K_W-1:0];
        REG_GEN_UPPER:      cfg_nxt.gen_upper      = pwdata[GEN_W-1:0];
        REG_GEN_LOWER:      cfg_nxt.gen_lower      = pwdata[GEN_W-1:0];
        REG_TAIL_BITING:    cfg_nxt.tail_biting    = pwdata[0];
        REG_REPEAT_COUNT:   cfg_nxt.repeat_count   = pwdata[REP_W-1:0];
        REG_PUNCT_LEN:      cfg_nxt.punct_len      = pwdata[PLEN_W-1:0];
        REG_PUNCT_MASK:     cfg_nxt.punct_mask     = pwdata[PMASK_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CONSTRAINT_LEN: prdata = 32'(cfg_r.constraint_len);
      REG_GEN_UPPER:      prdata = 32'(cfg_r.gen_upper);
      REG_GEN_LOWER:      prdata = 32'(cfg_r.gen_lower);
      REG_TAIL_BITING:    prdata = 32'(cfg_r.tail_biting);
      REG_REPEAT_COUNT:   prdata = 32'(cfg_r.repeat_count);
      REG_PUNCT_LEN:      prdata = 32'(cfg_r.punct_len);
      REG_PUNCT_MASK:     prdata = 32'(cfg_r.punct_mask);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.constraint_len <= K_W'(7);
      cfg_r.gen_upper      <= GEN_W'(121);
      cfg_r.gen_lower      <= GEN_W'(91);
      cfg_r.tail_biting    <= 1'b0;
      cfg_r.repeat_count   <= '0;
      cfg_r.punct_len      <= PLEN_W'(1);
      cfg_r.punct_mask     <= PMASK_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* design/cep_front.sv */
`timescale 1ns / 1ps
module cep_front import cep_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  cep_in_if.sink      in_ch,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_ready
);

  typedef enum logic [1:0] {
    F_IDLE   = 2'b01,
    F_REPLAY = 2'b10
  } fstate_t;

  fstate_t state_r, state_nxt;
  logic [HIST_W-1:0] shift_r, shift_nxt;
  logic [HIST_W-1:0] store_r, store_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [HIDX_W-1:0] idx_r, idx_nxt;

  logic [KE_W-1:0]  k;
  int               km1;
  logic             cur_bit;
  logic [REG_W-1:0] sreg;
  logic             preload;
  logic             replay;
  logic             accept;
  logic             replay_last;

  // K-bit register: history below, new bit on top at K-1
  function automatic logic [REG_W-1:0] build_reg(input logic [HIST_W-1:0] hist,
                                                 input logic b, input int kv);
    logic [REG_W-1:0] r;
    r = '0;
    for (int i = 0; i < HIST_W; i++) r[i] = (i < kv - 1) ? hist[i] : 1'b0;
    for (int i = 0; i < REG_W; i++) begin
      if (i == kv - 1) r[i] = b;
    end
    return r;
  endfunction

  always_comb begin
    k           = eff_k(cfg.constraint_len);
    km1         = int'(k) - 1;
    cur_bit     = (state_r == F_REPLAY) ? store_r[idx_r] : in_ch.msg_bit;
    sreg        = build_reg(shift_r, cur_bit, int'(k));
    preload     = cfg.tail_biting && (int'(count_r) < km1);
    replay      = in_ch.final_bit && cfg.tail_biting &&
                  (!preload || (int'(count_r) + 1 >= km1));
    replay_last = (int'(idx_r) == km1 - 1);
  end

  assign in_ch.ready = (state_r == F_IDLE) && q_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    q_valid    = 1'b0;
    q_cmd.sreg = sreg;
    q_cmd.emit = 1'b1;
    q_cmd.last = 1'b1;
    q_cmd.fin  = 1'b1;
    unique case (state_r)
      F_IDLE: begin
        q_valid    = in_ch.valid;
        q_cmd.emit = !preload;
        q_cmd.last = !replay;
        q_cmd.fin  = in_ch.final_bit;
      end
      F_REPLAY: begin
        q_valid    = 1'b1;
        q_cmd.last = replay_last;
      end
      default: q_valid = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    shift_nxt = shift_r;
    store_nxt = store_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          shift_nxt = sreg[REG_W-1:1];
          if (preload) begin
            store_nxt = store_r | (HIST_W'(in_ch.msg_bit) << count_r);
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_ch.final_bit) begin
            if (replay) begin
              state_nxt = F_REPLAY;
              idx_nxt   = '0;
            end else begin
              shift_nxt = '0;
              store_nxt = '0;
              count_nxt = '0;
            end
          end
        end
      end
      F_REPLAY: begin
        if (q_ready) begin
          shift_nxt = sreg[REG_W-1:1];
          idx_nxt   = idx_r + HIDX_W'(1);
          if (replay_last) begin
            state_nxt = F_IDLE;
            shift_nxt = '0;
            store_nxt = '0;
            count_nxt = '0;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      shift_r <= '0;
      store_r <= '0;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      shift_r <= shift_nxt;
      store_r <= store_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

/* design/cep_queue.sv */
`timescale 1ns / 1ps
module cep_queue import cep_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop_ready
);

  // QDEPTH is a power of two so the pointers wrap on their own
  cmd_t mem_r [QDEPTH];
  logic [QIDX_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_nxt  = push ? wr_r + QIDX_W'(1) : wr_r;
    rd_nxt  = pop ? rd_r + QIDX_W'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    if (pop && !push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_cmd;
  end

endmodule

/* design/cep_back.sv */
`timescale 1ns / 1ps
module cep_back import cep_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   cmd_valid,
  input  cmd_t   cmd,
  output logic   cmd_ready,
  cep_out_if.source out_ch
);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_RUN   = 3'b010,
    B_FLUSH = 3'b100
  } bstate_t;

  bstate_t state_r, state_nxt;
  logic              g_upper_r, g_upper_nxt;
  logic              g_lower_r, g_lower_nxt;
  logic              last_r, last_nxt;
  logic              fin_r, fin_nxt;
  logic [CAND_W-1:0] cand_r, cand_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic              pend_bit_r, pend_bit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_code_r, out_code_nxt;
  logic              out_run_r, out_run_nxt;
  logic              out_msg_r, out_msg_nxt;

  logic [PLEN_W-1:0] len_eff;
  logic [POS_W-1:0]  pos_use;
  logic [POS_W-1:0]  pos_adv;
  logic              keep;
  logic              cand_bit;
  logic [CAND_W-1:0] cand_last;
  logic              out_free;
  int                reps;

  function automatic logic mask_bit(input logic [PMASK_W-1:0] m, input logic [POS_W-1:0] p);
    logic b;
    b = 1'b0;
    for (int j = 0; j < PMASK_W; j++) begin
      if (int'(p) == j) b = m[j];
    end
    return b;
  endfunction

  always_comb begin
    len_eff = cfg.punct_len;
    if (int'(cfg.punct_len) > MAX_PATTERN) len_eff = PLEN_W'(MAX_PATTERN);
    pos_use = (int'(pos_r) >= int'(len_eff)) ? '0 : pos_r;
    pos_adv = (int'(pos_use) + 1 >= int'(len_eff)) ? '0 : pos_use + POS_W'(1);
    keep    = (len_eff != '0) && mask_bit(cfg.punct_mask, pos_use);

    reps = int'(cfg.repeat_count);
    if (reps == 0) reps = 1;
    if (reps > MAX_REPEAT) reps = MAX_REPEAT;
    cand_last = CAND_W'(2 * reps - 1);

    // pairs go upper then lower
    cand_bit = cand_r[0] ? g_lower_r : g_upper_r;
  end

  assign out_free          = !out_valid_r || out_ch.ready;
  assign cmd_ready         = (state_r == B_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.code_bit   = out_code_r;
  assign out_ch.run_end    = out_run_r;
  assign out_ch.message_end = out_msg_r;

  // One kept bit is held back so the last of a run can be flagged.
  always_comb begin
    state_nxt      = state_r;
    g_upper_nxt    = g_upper_r;
    g_lower_nxt    = g_lower_r;
    last_nxt       = last_r;
    fin_nxt        = fin_r;
    cand_nxt       = cand_r;
    pos_nxt        = pos_r;
    pend_valid_nxt = pend_valid_r;
    pend_bit_nxt   = pend_bit_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_code_nxt   = out_code_r;
    out_run_nxt    = out_run_r;
    out_msg_nxt    = out_msg_r;

    unique case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          g_upper_nxt = ^(cmd.sreg & REG_W'(cfg.gen_upper));
          g_lower_nxt = ^(cmd.sreg & REG_W'(cfg.gen_lower));
          last_nxt    = cmd.last;
          fin_nxt     = cmd.fin;
          cand_nxt    = '0;
          if (cmd.emit) state_nxt = B_RUN;
          else if (cmd.last) state_nxt = B_FLUSH;
        end
      end
      B_RUN: begin
        if (!(keep && pend_valid_r && !out_free)) begin
          if (len_eff != '0) pos_nxt = pos_adv;
          if (keep) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_code_nxt  = pend_bit_r;
              out_run_nxt   = 1'b0;
              out_msg_nxt   = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_bit_nxt   = cand_bit;
          end
          if (cand_r == cand_last) begin
            state_nxt = last_r ? B_FLUSH : B_IDLE;
          end else begin
            cand_nxt = cand_r + CAND_W'(1);
          end
        end
      end
      B_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = B_IDLE;
          if (fin_r) pos_nxt = '0;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_code_nxt   = pend_bit_r;
          out_run_nxt    = 1'b1;
          out_msg_nxt    = fin_r;
          pend_valid_nxt = 1'b0;
          state_nxt      = B_IDLE;
          if (fin_r) pos_nxt = '0;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      cand_r       <= '0;
      pos_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cand_r       <= cand_nxt;
      pos_r        <= pos_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    g_upper_r  <= g_upper_nxt;
    g_lower_r  <= g_lower_nxt;
    last_r     <= last_nxt;
    fin_r      <= fin_nxt;
    pend_bit_r <= pend_bit_nxt;
    out_code_r <= out_code_nxt;
    out_run_r  <= out_run_nxt;
    out_msg_r  <= out_msg_nxt;
  end

endmodule

/* design/conv_encoder_repeat_puncture.sv */
`timescale 1ns / 1ps
// Rate-1/2 convolutional encoder with pair repetition, cyclic puncturing and
// optional tail-biting. Message bits enter on in_ch with final_bit on the last
// one; kept coded bits leave on out_ch, run_end marking the last bit caused by
// a request and message_end the last bit of a message. The front end shifts
// the encoder register and queues one command per clocked bit (K-1 extra
// commands replay the preload after a tail-biting final bit); the back end
// walks the repeated pair one candidate bit per cycle through the puncture
// pattern, holding while a kept bit waits on a stalled output, and closes
// a request's run in its flush state. Registers sit at byte address
// 4*index on the APB port and should be
// written only while the block is idle.
module conv_encoder_repeat_puncture import cep_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  cep_in_if.sink            in_ch,
  cep_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  logic q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  cmd_t q_in_cmd, q_out_cmd;

  assign pready = 1'b1;

  cep_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  cep_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .q_valid (q_in_valid),
    .q_cmd   (q_in_cmd),
    .q_ready (q_in_ready)
  );

  cep_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_in_valid),
    .push_cmd   (q_in_cmd),
    .push_ready (q_in_ready),
    .pop_valid  (q_out_valid),
    .pop_cmd    (q_out_cmd),
    .pop_ready  (q_out_ready)
  );

  cep_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (q_out_valid),
    .cmd       (q_out_cmd),
    .cmd_ready (q_out_ready),
    .out_ch    (out_ch)
  );

endmodule

/* design/cep_checker.sv */
`timescale 1ns / 1ps
module cep_checker (
  input logic       clk,
  input logic       rst_n,
  cep_out_if.source out_ch,
  input logic       pready
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.code_bit) &&
      $stable(out_ch.run_end) && $stable(out_ch.message_end))
    else $error("stalled result changed");

  a_msg_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.message_end |-> out_ch.run_end)
    else $error("message_end without run_end");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind conv_encoder_repeat_puncture cep_checker u_cep_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .out_ch (out_ch),
  .pready (pready)
);

/* tb/sv/tb_conv_encoder_repeat_puncture.sv */
`timescale 1ns / 1ps
module tb_conv_encoder_repeat_puncture;
  import cep_pkg::*;

  localparam int SETTLE_CYCLES  = 150;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 28;
  localparam int RANDOM_PHASES  = 12;

  typedef struct packed {
    logic code;
    logic run_end;
    logic msg_end;
  } coded_bit_t;

  class coded_bit_tracker;
    cfg_t              regs;
    logic [HIST_W-1:0] hist;
    logic [HIST_W-1:0] preload;
    int unsigned       n_preload;
    int unsigned       pos;
    coded_bit_t        step_bits[$];
    coded_bit_t        coded_bits_due[$];
    int                mismatches;

    function new();
      mismatches = 0;
      regs.constraint_len = 3'd7;
      regs.gen_upper      = 7'd121;
      regs.gen_lower      = 7'd91;
      regs.tail_biting    = 1'b0;
      regs.repeat_count   = 3'd0;
      regs.punct_len      = 5'd1;
      regs.punct_mask     = 16'd1;
      clear_message();
    endfunction

    function void clear_message();
      hist      = '0;
      preload   = '0;
      n_preload = 0;
      pos       = 0;
    endfunction

    function void set_reg(logic [REGIDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        REG_CONSTRAINT_LEN: regs.constraint_len = v[K_W-1:0];
        REG_GEN_UPPER:      regs.gen_upper      = v[GEN_W-1:0];
        REG_GEN_LOWER:      regs.gen_lower      = v[GEN_W-1:0];
        REG_TAIL_BITING:    regs.tail_biting    = v[0];
        REG_REPEAT_COUNT:   regs.repeat_count   = v[REP_W-1:0];
        REG_PUNCT_LEN:      regs.punct_len      = v[PLEN_W-1:0];
        REG_PUNCT_MASK:     regs.punct_mask     = v[PMASK_W-1:0];
        default: ;
      endcase
    endfunction

    function int k_eff();
      int k;
      k = int'(regs.constraint_len);
      if (k < 2) k = 2;
      if (k > MAX_CONSTRAINT) k = MAX_CONSTRAINT;
      return k;
    endfunction

    function int due_count();
      return coded_bits_due.size();
    endfunction

    // walk one repeated bit through the puncture pattern
    function void puncture_keep(logic b);
      int len;
      logic keep;
      coded_bit_t cb;
      len = int'(regs.punct_len);
      if (len == 0) return;
      if (len > MAX_PATTERN) len = MAX_PATTERN;
      if (pos >= len) pos = 0;
      keep = (pos < PMASK_W) ? regs.punct_mask[pos] : 1'b0;
      pos  = (pos + 1 >= len) ? 0 : pos + 1;
      if (keep) begin
        cb.code    = b;
        cb.run_end = 1'b0;
        cb.msg_end = 1'b0;
        step_bits.push_back(cb);
      end
    endfunction

    function void shift_and_code(logic b, bit emit);
      int k;
      int reps;
      logic [REG_W-1:0] hmask;
      logic [REG_W-1:0] r;
      logic g1;
      logic g0;
      k     = k_eff();
      hmask = (REG_W'(1) << (k - 1)) - REG_W'(1);
      r     = ({1'b0, hist} & hmask) | (REG_W'(b) << (k - 1));
      hist  = r[REG_W-1:1];
      if (emit) begin
        g1   = ^(r & regs.gen_upper);
        g0   = ^(r & regs.gen_lower);
        reps = int'(regs.repeat_count);
        if (reps == 0) reps = 1;
        if (reps > MAX_REPEAT) reps = MAX_REPEAT;
        for (int i = 0; i < reps; i++) begin
          puncture_keep(g1);
          puncture_keep(g0);
        end
      end
    endfunction

    task note_request(logic m, logic f);
      int k;
      k = k_eff();
      step_bits.delete();
      if (regs.tail_biting && n_preload < k - 1) begin
        preload[n_preload] = m;
        n_preload++;
        shift_and_code(m, 1'b0);
      end else begin
        shift_and_code(m, 1'b1);
      end
      if (f) begin
        // replay the preloaded head once the message closes
        if (regs.tail_biting && n_preload >= k - 1) begin
          for (int i = 0; i < k - 1; i++) shift_and_code(preload[i], 1'b1);
        end
        clear_message();
      end
      if (step_bits.size() > 0) begin
        step_bits[step_bits.size()-1].run_end = 1'b1;
        step_bits[step_bits.size()-1].msg_end = f;
      end
      foreach (step_bits[i]) coded_bits_due.push_back(step_bits[i]);
    endtask

    task report_mismatch(string what);
      mismatches++;
      $display("%0t: mismatch: %s", $time, what);
    endtask

    task check_coded_bit(logic code, logic run_end, logic msg_end);
      coded_bit_t want;
      if (coded_bits_due.size() == 0) begin
        report_mismatch($sformatf("coded bit %b with nothing due", code));
        return;
      end
      want = coded_bits_due.pop_front();
      if (code !== want.code)
        report_mismatch($sformatf("code_bit %b, want %b", code, want.code));
      if (run_end !== want.run_end)
        report_mismatch($sformatf("run_end %b, want %b", run_end, want.run_end));
      if (msg_end !== want.msg_end)
        report_mismatch($sformatf("message_end %b, want %b", msg_end, want.msg_end));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  bit hold_out;
  bit no_idle;
  int quiet_cycles;

  coded_bit_tracker codes = new();

  cep_in_if  in_ch ();
  cep_out_if out_ch ();

  conv_encoder_repeat_puncture DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      codes.note_request(in_ch.msg_bit, in_ch.final_bit);
    if (rst_n && out_ch.valid && out_ch.ready)
      codes.check_coded_bit(out_ch.code_bit, out_ch.run_end, out_ch.message_end);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[conv_encoder_repeat_puncture] ERROR");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        hold_out = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task write_reg(logic [REGIDX_W-1:0] idx, logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    codes.set_reg(idx, v);
  endtask

  task program_settings(cfg_t c);
    write_reg(REG_CONSTRAINT_LEN, 32'(c.constraint_len));
    write_reg(REG_GEN_UPPER,      32'(c.gen_upper));
    write_reg(REG_GEN_LOWER,      32'(c.gen_lower));
    write_reg(REG_TAIL_BITING,    32'(c.tail_biting));
    write_reg(REG_REPEAT_COUNT,   32'(c.repeat_count));
    write_reg(REG_PUNCT_LEN,      32'(c.punct_len));
    write_reg(REG_PUNCT_MASK,     32'(c.punct_mask));
  endtask

  function cfg_t settings(int k, int gu, int gl, int tb, int rep, int plen, int mask);
    cfg_t c;
    c.constraint_len = K_W'(k);
    c.gen_upper      = GEN_W'(gu);
    c.gen_lower      = GEN_W'(gl);
    c.tail_biting    = 1'(tb);
    c.repeat_count   = REP_W'(rep);
    c.punct_len      = PLEN_W'(plen);
    c.punct_mask     = PMASK_W'(mask);
    return c;
  endfunction

  function cfg_t random_settings();
    int plen;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) plen = 0;
    else if (pick == 1) plen = $urandom_range(MAX_PATTERN + 1, 31);
    else plen = $urandom_range(1, MAX_PATTERN);
    return settings($urandom_range(0, 7), $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 1), $urandom_range(0, 7), plen,
                    $urandom_range(0, 16'hFFFF));
  endfunction

  task send_item(logic m, logic f);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.msg_bit   <= m;
    in_ch.final_bit <= f;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // wait for every due bit, then let replay or dropped bits finish
  task drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (codes.due_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task random_messages(int n_items);
    int msg_left;
    logic fin;
    msg_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (msg_left == 0)
        msg_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 9);
      msg_left--;
      // now and then a message is cut short
      fin = (msg_left == 0) || ($urandom_range(0, 29) == 0);
      if (fin) msg_left = 0;
      send_item(1'($urandom_range(0, 1)), fin);
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.msg_bit   <= 1'b0;
    in_ch.final_bit <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    hold_out         = 1'b0;
    no_idle          = 1'b0;
    quiet_cycles     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // settings after reset
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
    drain();

    // tail-biting, K=3: short message, exactly K-1 bits, then a full one
    program_settings(settings(3, 7'b1011011, 7'h05, 1, 1, MAX_PATTERN, 16'hFFFF));
    send_item(1'b1, 1'b1);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b1);
    drain();

    // zero pattern length
    program_settings(settings(5, 7'h2D, 7'h33, 0, 2, 0, 16'hFFFF));
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
    drain();

    // K below 2, repeat and pattern length saturate; message left open
    program_settings(settings(0, 127, 127, 1, 7, 31, 16'hA5C3));
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    drain();

    // new K in the middle of that message
    program_settings(settings(4, 7'h0B, 7'h7F, 1, 5, MAX_PATTERN + 1, 16'hFFFF));
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0)
        program_settings(settings(7, 127, 127, 1, 7, 31, 16'hFFFF));
      else if (p == 1)
        program_settings(settings(0, 0, 0, 0, 0, 0, 0));
      else if (p == 2)
        program_settings(settings(7, $urandom_range(0, 127), $urandom_range(0, 127), 0,
                                  MAX_REPEAT, MAX_PATTERN, 16'hFFFF));
      else
        program_settings(random_settings());
      if (p == 2) hold_out = 1'b1;
      if (p >= RANDOM_PHASES - 2) no_idle = 1'b1;
      random_messages(PHASE_ITEMS);
      drain();
    end

    if (codes.mismatches == 0 && codes.due_count() == 0)
      $display("[conv_encoder_repeat_puncture] OK");
    else
      $display("[conv_encoder_repeat_puncture] ERROR");
    $finish;
  end

endmodule
